[hw/rtl/imh_pkg.sv]
// Shared types and constants for the image map hit tester.
// Used by imh_dp, imh_ctrl and image_map_hit_test; no dependencies.
package imh_pkg;

   localparam int DEF_MAX_AREAS  = 16;
   localparam int DEF_MAX_COORDS = 256;
   localparam int DEF_COORD_BITS = 16;

   localparam int RECT_MIN   = 4;
   localparam int CIRCLE_MIN = 3;
   localparam int POLY_MIN   = 6;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;
   localparam int KIND_W     = 3;
   localparam int IDX_W      = 4;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIRST  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LINK   = 3'd4;

   localparam logic [1:0] SHAPE_DEFAULT = 2'd0;
   localparam logic [1:0] SHAPE_RECT    = 2'd1;
   localparam logic [1:0] SHAPE_POLY    = 2'd2;
   localparam logic [1:0] SHAPE_CIRCLE  = 2'd3;

   localparam logic [1:0] STS_OK          = 2'd0;
   localparam logic [1:0] STS_TABLE_FULL  = 2'd1;
   localparam logic [1:0] STS_STORE_FULL  = 2'd2;
   localparam logic [1:0] STS_NO_AREA     = 2'd3;

   // flag bits kept per area
   localparam int FLAG_URL  = 0;
   localparam int FLAG_HREF = 1;
   localparam int FLAG_SUP  = 2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_OPEN,
      OP_APPEND,
      OP_AREA_RD,
      OP_SHIFT,
      OP_MUL_DX,
      OP_MUL_DY,
      OP_MUL_R,
      OP_MUL_EDGE,
      OP_PAR_CLR,
      OP_PAR_XA,
      OP_PAR_Q
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rd_en;
      logic      div_start;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [1:0]        shape;
      logic [2:0]        flags;
      logic              table_full;
      logic              store_full;
      logic              no_area;
      logic              ld_busy;
      logic              div_busy;
      logic              rect_hit;
      logic              r_neg;
      logic              circ_hit;
      logic              y_same;
      logic              x_same;
      logic              parity;
   } stat_type;

   typedef struct packed {
      logic             sup;
      logic             link;
      logic [IDX_W-1:0] idx;
      logic             hit;
      logic [1:0]       status;
   } result_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_AREA_RD,
      ST_AREA_CHK,
      ST_FETCH,
      ST_FWAIT,
      ST_RECT,
      ST_CIRC0,
      ST_CIRC1,
      ST_CIRC2,
      ST_CIRC3,
      ST_POLY0,
      ST_EDGE,
      ST_DIV,
      ST_DWAIT,
      ST_PNEXT,
      ST_HIT,
      ST_AREA_NEXT,
      ST_DONE
   } ctrl_state_type;

endpackage

[hw/rtl/imh_div.sv]
// Bit-serial signed divider, quotient truncated toward zero.
// Depends on nothing but its parameters.
module imh_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [NUM_W-1:0]  num,
   input  logic signed [DEN_W-1:0]  den,
   output logic                     busy,
   output logic signed [NUM_W:0]    quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] mag_ff, mag_in;
   logic [DEN_W-1:0] dmag_ff, dmag_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   rem_sh, rem_sub;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, mag_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, dmag_ff};
      ge      = rem_sh >= {1'b0, dmag_ff};
      mag_in  = mag_ff;
      dmag_in = dmag_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         mag_in  = num[NUM_W-1] ? (~num + 1'b1) : num;
         dmag_in = den[DEN_W-1] ? (~den + 1'b1) : den;
         neg_in  = num[NUM_W-1] ^ den[DEN_W-1];
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         mag_in  = {mag_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff  <= mag_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
   end

   assign busy = busy_ff;
   assign quot = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});

endmodule

[hw/rtl/imh_dp.sv]
// Datapath: area table, coordinate store, shape arithmetic, shared multiplier.
// Depends on imh_pkg and imh_div.
module imh_dp #(
   parameter int MAX_AREAS  = imh_pkg::DEF_MAX_AREAS,
   parameter int MAX_COORDS = imh_pkg::DEF_MAX_COORDS,
   parameter int COORD_BITS = imh_pkg::DEF_COORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  imh_pkg::cmd_type                    cmd,
   input  logic [$clog2(MAX_COORDS+1)-1:0]     rd_off,
   input  logic [1:0]                          rd_tgt,
   input  logic [$clog2(MAX_AREAS)-1:0]        area_idx,
   input  logic [imh_pkg::KIND_W-1:0]          kind,
   input  logic [1:0]                          shape,
   input  logic                                has_url,
   input  logic                                href_nonempty,
   input  logic                                suppress,
   input  logic signed [15:0]                  coord_value,
   input  logic signed [15:0]                  x_pos,
   input  logic signed [15:0]                  y_pos,
   output imh_pkg::stat_type                   st,
   output logic [$clog2(MAX_AREAS+1)-1:0]      area_count,
   output logic [$clog2(MAX_COORDS+1)-1:0]     area_len
);
   import imh_pkg::*;

   localparam int AI = $clog2(MAX_AREAS);
   localparam int NW = $clog2(MAX_AREAS + 1);
   localparam int AW = $clog2(MAX_COORDS);
   localparam int LW = $clog2(MAX_COORDS + 1);
   localparam int CW = COORD_BITS;
   localparam int W  = (COORD_BITS > 16) ? COORD_BITS : 16;
   localparam int PW = 2 * (W + 1);
   localparam logic signed [W-1:0] CHI = W'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [W-1:0] CLO = -CHI - W'(1);

   // item registers
   logic [KIND_W-1:0]    kind_ff;
   logic [1:0]           shape_ff;
   logic [2:0]           flags_ff;
   logic signed [15:0]   coord_ff, x_ff, y_ff;

   // control state
   logic [NW-1:0] count_ff;
   logic [LW-1:0] fill_ff, cur_len_ff;
   logic          iss_ff, par_ff;

   // stores
   logic [1:0]           shape_mem [MAX_AREAS];
   logic [2:0]           flag_mem  [MAX_AREAS];
   logic [AW-1:0]        start_mem [MAX_AREAS];
   logic [LW-1:0]        len_mem   [MAX_AREAS];
   logic signed [CW-1:0] cmem      [MAX_COORDS];

   logic [1:0]           a_shape_ff;
   logic [2:0]           a_flags_ff;
   logic [AW-1:0]        a_start_ff;
   logic [LW-1:0]        a_len_ff;
   logic signed [CW-1:0] rd_q_ff;
   logic [1:0]           tgt_ff;

   logic signed [W-1:0]  c_ff [4];
   logic signed [PW-1:0] prod_ff;
   logic signed [PW:0]   acc_ff;

   logic [AI-1:0]        cnt_idx, last_idx;
   logic [LW:0]          addr_sum;
   logic [AW-1:0]        rd_addr;
   logic signed [W-1:0]  cin_w, csat, x_w, y_w;
   logic signed [W:0]    mul_a, mul_b, dx, dy, dya, dxb, den;
   logic signed [PW:0]   quot;
   logic signed [PW+1:0] xq;
   logic                 div_busy, q_cross, xa_ge;

   assign cnt_idx  = count_ff[AI-1:0];
   assign last_idx = AI'(count_ff - 1'b1);
   assign addr_sum = (LW+1)'(a_start_ff) + (LW+1)'(rd_off);
   assign rd_addr  = addr_sum[AW-1:0];
   assign x_w      = W'(x_ff);
   assign y_w      = W'(y_ff);
   assign cin_w    = W'(coord_ff);
   assign csat     = (cin_w > CHI) ? CHI : ((cin_w < CLO) ? CLO : cin_w);

   assign dx   = (W+1)'(c_ff[0]) - (W+1)'(x_w);
   assign dy   = (W+1)'(c_ff[1]) - (W+1)'(y_w);
   assign dya  = (W+1)'(c_ff[1]) - (W+1)'(y_w);
   assign dxb  = (W+1)'(c_ff[2]) - (W+1)'(c_ff[0]);
   assign den  = (W+1)'(c_ff[3]) - (W+1)'(c_ff[1]);
   assign xa_ge = c_ff[0] >= x_w;
   assign xq    = (PW+2)'(c_ff[0]) - (PW+2)'(quot);
   assign q_cross = xq >= (PW+2)'(x_w);

   always_comb begin
      case (cmd.op)
         OP_MUL_DX: begin
            mul_a = dx;
            mul_b = dx;
         end
         OP_MUL_DY: begin
            mul_a = dy;
            mul_b = dy;
         end
         OP_MUL_R: begin
            mul_a = (W+1)'(c_ff[2]);
            mul_b = (W+1)'(c_ff[2]);
         end
         default: begin
            mul_a = dya;
            mul_b = dxb;
         end
      endcase
   end

   imh_div #(
      .NUM_W(PW),
      .DEN_W(W + 1)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (prod_ff),
      .den   (den),
      .busy  (div_busy),
      .quot  (quot)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         fill_ff    <= '0;
         cur_len_ff <= '0;
         iss_ff     <= 1'b0;
         par_ff     <= 1'b0;
      end else begin
         iss_ff <= cmd.rd_en;
         case (cmd.op)
            OP_CLEAR: begin
               count_ff <= '0;
               fill_ff  <= '0;
            end
            OP_OPEN: begin
               count_ff   <= count_ff + 1'b1;
               cur_len_ff <= '0;
            end
            OP_APPEND: begin
               fill_ff    <= fill_ff + 1'b1;
               cur_len_ff <= cur_len_ff + 1'b1;
            end
            OP_PAR_CLR: par_ff <= 1'b0;
            OP_PAR_XA:  par_ff <= par_ff ^ xa_ge;
            OP_PAR_Q:   par_ff <= par_ff ^ q_cross;
            default: ;
         endcase
      end
   end

   // stores and payload
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         kind_ff  <= kind;
         shape_ff <= shape;
         flags_ff <= {suppress, href_nonempty, has_url};
         coord_ff <= coord_value;
         x_ff     <= x_pos;
         y_ff     <= y_pos;
      end
      if (cmd.op == OP_OPEN) begin
         shape_mem[cnt_idx] <= shape_ff;
         flag_mem[cnt_idx]  <= flags_ff;
         start_mem[cnt_idx] <= fill_ff[AW-1:0];
         len_mem[cnt_idx]   <= '0;
      end
      if (cmd.op == OP_APPEND) begin
         cmem[fill_ff[AW-1:0]] <= CW'(csat);
         len_mem[last_idx]     <= cur_len_ff + 1'b1;
      end
      if (cmd.op == OP_AREA_RD) begin
         a_shape_ff <= shape_mem[area_idx];
         a_flags_ff <= flag_mem[area_idx];
         a_start_ff <= start_mem[area_idx];
         a_len_ff   <= len_mem[area_idx];
      end
      if (cmd.rd_en) begin
         rd_q_ff <= cmem[rd_addr];
      end
      tgt_ff <= rd_tgt;
      if (cmd.op == OP_SHIFT) begin
         c_ff[0] <= c_ff[2];
         c_ff[1] <= c_ff[3];
      end
      if (iss_ff) begin
         c_ff[tgt_ff] <= W'(rd_q_ff);
      end
      case (cmd.op)
         OP_MUL_DX, OP_MUL_EDGE: prod_ff <= mul_a * mul_b;
         OP_MUL_DY: begin
            acc_ff  <= (PW+1)'(prod_ff);
            prod_ff <= mul_a * mul_b;
         end
         OP_MUL_R: begin
            acc_ff  <= acc_ff + (PW+1)'(prod_ff);
            prod_ff <= mul_a * mul_b;
         end
         default: ;
      endcase
   end

   always_comb begin
      st.kind       = kind_ff;
      st.shape      = a_shape_ff;
      st.flags      = a_flags_ff;
      st.table_full = count_ff == NW'(MAX_AREAS);
      st.store_full = fill_ff == LW'(MAX_COORDS);
      st.no_area    = count_ff == '0;
      st.ld_busy    = iss_ff;
      st.div_busy   = div_busy;
      st.rect_hit   = !(c_ff[0] > c_ff[2]) && !(c_ff[1] > c_ff[3]) &&
                      (x_w >= c_ff[0]) && (x_w <= c_ff[2]) &&
                      (y_w >= c_ff[1]) && (y_w <= c_ff[3]);
      st.r_neg      = c_ff[2][W-1];
      st.circ_hit   = acc_ff <= (PW+1)'(prod_ff);
      st.y_same     = (c_ff[1] >= y_w) == (c_ff[3] >= y_w);
      st.x_same     = xa_ge == (c_ff[2] >= x_w);
      st.parity     = par_ff;
   end

   assign area_count = count_ff;
   assign area_len   = a_len_ff;

endmodule

[hw/rtl/imh_ctrl.sv]
// Sequencer: walks the areas, fetches coordinates, steps the shape tests.
// Depends on imh_pkg.
module imh_ctrl #(
   parameter int MAX_AREAS  = imh_pkg::DEF_MAX_AREAS,
   parameter int MAX_COORDS = imh_pkg::DEF_MAX_COORDS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                out_free,
   output logic                                post,
   output imh_pkg::result_type                 res,
   output imh_pkg::cmd_type                    cmd,
   output logic [$clog2(MAX_COORDS+1)-1:0]     rd_off,
   output logic [1:0]                          rd_tgt,
   output logic [$clog2(MAX_AREAS)-1:0]        area_idx,
   input  imh_pkg::stat_type                   st,
   input  logic [$clog2(MAX_AREAS+1)-1:0]      area_count,
   input  logic [$clog2(MAX_COORDS+1)-1:0]     area_len
);
   import imh_pkg::*;

   localparam int AI = $clog2(MAX_AREAS);
   localparam int NW = $clog2(MAX_AREAS + 1);
   localparam int LW = $clog2(MAX_COORDS + 1);

   ctrl_state_type state_ff, state_in, ret_ff, ret_in;
   logic [NW-1:0]  i_ff, i_in, i_nx;
   logic [LW-1:0]  vo_ff, vo_in, fo_ff, fo_in, poly_end;
   logic [LW:0]    vo_nx;
   logic [1:0]     ft_ff, ft_in;
   logic [2:0]     fn_ff, fn_in;
   result_type     res_ff, res_in;

   assign poly_end = {area_len[LW-1:1], 1'b0};
   assign vo_nx    = (LW+1)'(vo_ff) + (LW+1)'(2);
   assign i_nx     = i_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ret_ff <= ret_in;
      i_ff   <= i_in;
      vo_ff  <= vo_in;
      fo_ff  <= fo_in;
      ft_ff  <= ft_in;
      fn_ff  <= fn_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      i_in          = i_ff;
      vo_in         = vo_ff;
      fo_in         = fo_ff;
      ft_in         = ft_ff;
      fn_in         = fn_ff;
      res_in        = res_ff;
      cmd.op        = OP_NONE;
      cmd.rd_en     = 1'b0;
      cmd.div_start = 1'b0;
      req_ready     = 1'b0;
      post          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            res_in   = '0;
            i_in     = '0;
            state_in = ST_DONE;
            case (st.kind)
               KIND_CLEAR: cmd.op = OP_CLEAR;
               KIND_OPEN: begin
                  if (st.table_full) begin
                     res_in.status = STS_TABLE_FULL;
                  end else begin
                     cmd.op = OP_OPEN;
                  end
               end
               KIND_APPEND: begin
                  if (st.no_area) begin
                     res_in.status = STS_NO_AREA;
                  end else if (st.store_full) begin
                     res_in.status = STS_STORE_FULL;
                  end else begin
                     cmd.op = OP_APPEND;
                  end
               end
               KIND_FIRST, KIND_LINK: begin
                  if (!st.no_area) begin
                     state_in = ST_AREA_RD;
                  end
               end
               default: ;
            endcase
         end
         ST_AREA_RD: begin
            cmd.op   = OP_AREA_RD;
            state_in = ST_AREA_CHK;
         end
         ST_AREA_CHK: begin
            state_in = ST_AREA_NEXT;
            fo_in    = '0;
            ft_in    = 2'd0;
            if (st.kind != KIND_LINK || st.flags[FLAG_HREF]) begin
               case (st.shape)
                  SHAPE_RECT: begin
                     if (area_len >= LW'(RECT_MIN)) begin
                        fn_in    = 3'd4;
                        ret_in   = ST_RECT;
                        state_in = ST_FETCH;
                     end
                  end
                  SHAPE_CIRCLE: begin
                     if (area_len >= LW'(CIRCLE_MIN)) begin
                        fn_in    = 3'd3;
                        ret_in   = ST_CIRC0;
                        state_in = ST_FETCH;
                     end
                  end
                  SHAPE_POLY: begin
                     if (area_len >= LW'(POLY_MIN)) begin
                        cmd.op   = OP_PAR_CLR;
                        fo_in    = poly_end - LW'(2);
                        ft_in    = 2'd2;
                        fn_in    = 3'd2;
                        ret_in   = ST_POLY0;
                        state_in = ST_FETCH;
                     end
                  end
                  default: state_in = ST_HIT;
               endcase
            end
         end
         ST_FETCH: begin
            cmd.rd_en = 1'b1;
            fo_in     = fo_ff + 1'b1;
            ft_in     = ft_ff + 1'b1;
            fn_in     = fn_ff - 1'b1;
            if (fn_ff == 3'd1) begin
               state_in = ST_FWAIT;
            end
         end
         ST_FWAIT: begin
            if (!st.ld_busy) begin
               state_in = ret_ff;
            end
         end
         ST_RECT: state_in = st.rect_hit ? ST_HIT : ST_AREA_NEXT;
         ST_CIRC0: begin
            if (st.r_neg) begin
               state_in = ST_AREA_NEXT;
            end else begin
               cmd.op   = OP_MUL_DX;
               state_in = ST_CIRC1;
            end
         end
         ST_CIRC1: begin
            cmd.op   = OP_MUL_DY;
            state_in = ST_CIRC2;
         end
         ST_CIRC2: begin
            cmd.op   = OP_MUL_R;
            state_in = ST_CIRC3;
         end
         ST_CIRC3: state_in = st.circ_hit ? ST_HIT : ST_AREA_NEXT;
         ST_POLY0: begin
            // last vertex becomes the trailing end of the closing edge
            cmd.op   = OP_SHIFT;
            vo_in    = '0;
            fo_in    = '0;
            ft_in    = 2'd2;
            fn_in    = 3'd2;
            ret_in   = ST_EDGE;
            state_in = ST_FETCH;
         end
         ST_EDGE: begin
            state_in = ST_PNEXT;
            if (!st.y_same) begin
               if (st.x_same) begin
                  cmd.op = OP_PAR_XA;
               end else begin
                  cmd.op   = OP_MUL_EDGE;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (!st.div_busy) begin
               cmd.op   = OP_PAR_Q;
               state_in = ST_PNEXT;
            end
         end
         ST_PNEXT: begin
            if (vo_nx >= (LW+1)'(poly_end)) begin
               state_in = st.parity ? ST_HIT : ST_AREA_NEXT;
            end else begin
               cmd.op   = OP_SHIFT;
               vo_in    = vo_nx[LW-1:0];
               fo_in    = vo_nx[LW-1:0];
               ft_in    = 2'd2;
               fn_in    = 3'd2;
               ret_in   = ST_EDGE;
               state_in = ST_FETCH;
            end
         end
         ST_HIT: begin
            res_in.hit = 1'b1;
            if (st.kind == KIND_FIRST) begin
               res_in.idx  = IDX_W'(i_ff);
               res_in.link = st.flags[FLAG_URL];
               res_in.sup  = st.flags[FLAG_SUP];
            end
            state_in = ST_DONE;
         end
         ST_AREA_NEXT: begin
            i_in     = i_nx;
            state_in = (i_nx == area_count) ? ST_DONE : ST_AREA_RD;
         end
         ST_DONE: begin
            if (out_free) begin
               post     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign res      = res_ff;
   assign rd_off   = fo_ff;
   assign rd_tgt   = ft_ff;
   assign area_idx = i_ff[AI-1:0];

endmodule

[hw/rtl/image_map_hit_test.sv]
// Top level of the image map hit tester: stream ports and result register.
// Depends on imh_pkg, imh_ctrl and imh_dp (which holds imh_div).
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  req     | in  | req_tvalid/req_tready | tuser kind, tdata area/coord/point
//  rsp     | out | rsp_tvalid/rsp_tready | tdata status, hit, index, flags
//
// One item is worked at a time: accepted in the idle state, then taken
// through the dispatch and done states; the done state posts the result to
// the output register. A query also reads and checks each area tested, runs
// the rect or circle test (a negative radius ends the circle test early), and
// for a polygon sets up, then fetches each vertex (one coordinate store read
// port), with a bit-serial divide of a 2*(W+1)-bit product for each edge whose
// ends lie either side of the point in both axes (W = max(COORD_BITS, 16)).
// Reset is synchronous and empties the table; the stores need no clearing.
// A result waits in the output register while the next item is taken; the
// sequencer stalls only when it has a second result and the register is full.
module image_map_hit_test #(
   parameter int MAX_AREAS  = imh_pkg::DEF_MAX_AREAS,
   parameter int MAX_COORDS = imh_pkg::DEF_MAX_COORDS,
   parameter int COORD_BITS = imh_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // kind [2:0]
   input  logic [imh_pkg::KIND_W-1:0]        req_tuser,
   // shape [1:0], has_url [2], href_nonempty [3], suppress [4],
   // coord_value [20:5], x_pos [36:21], y_pos [52:37], zero fill
   input  logic [imh_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [1:0], hit [2], area_index [6:3], area_has_link [7],
   // area_suppress [8], zero fill
   output logic [imh_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import imh_pkg::*;

   localparam int AI = $clog2(MAX_AREAS);
   localparam int NW = $clog2(MAX_AREAS + 1);
   localparam int LW = $clog2(MAX_COORDS + 1);

   cmd_type    cmd;
   stat_type   st;
   result_type res;
   logic [LW-1:0] rd_off, area_len;
   logic [1:0]    rd_tgt;
   logic [AI-1:0] area_idx;
   logic [NW-1:0] area_count;
   logic          post, out_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // the output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   imh_ctrl #(
      .MAX_AREAS  (MAX_AREAS),
      .MAX_COORDS (MAX_COORDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .out_free   (out_free),
      .post       (post),
      .res        (res),
      .cmd        (cmd),
      .rd_off     (rd_off),
      .rd_tgt     (rd_tgt),
      .area_idx   (area_idx),
      .st         (st),
      .area_count (area_count),
      .area_len   (area_len)
   );

   imh_dp #(
      .MAX_AREAS  (MAX_AREAS),
      .MAX_COORDS (MAX_COORDS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .rd_off        (rd_off),
      .rd_tgt        (rd_tgt),
      .area_idx      (area_idx),
      .kind          (req_tuser),
      .shape         (req_tdata[1:0]),
      .has_url       (req_tdata[2]),
      .href_nonempty (req_tdata[3]),
      .suppress      (req_tdata[4]),
      .coord_value   (req_tdata[20:5]),
      .x_pos         (req_tdata[36:21]),
      .y_pos         (req_tdata[52:37]),
      .st            (st),
      .area_count    (area_count),
      .area_len      (area_len)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (post) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'(res);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[tb/tb_image_map_hit_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for image_map_hit_test: area table loads, rect, circle
// and polygon queries, checked item by item. Depends on imh_pkg and the RTL.

class hit_scoreboard;
   // mirror of the block's area table
   int unsigned   n_areas;
   int unsigned   fill;
   logic [1:0]    shp [16];
   logic [2:0]    flg [16];
   int unsigned   st [16];
   int unsigned   len [16];
   longint        crds [256];
   logic [8:0]    pending [$];
   int            errors;

   function new();
      n_areas = 0;
      fill = 0;
      errors = 0;
      foreach (crds[i]) crds[i] = 0;
   endfunction

   function longint coord_at(int unsigned a, int i);
      longint idx;
      idx = longint'(st[a]) + i;
      if (i < 0 || idx >= 256) return 0;
      return crds[idx];
   endfunction

   // one crossing of the ray from (wx,wy) towards +x, division truncating
   function int unsigned crossing(longint xa, longint ya, longint xb, longint yb,
                                  longint wx, longint wy);
      longint den, q;
      if ((xa >= wx) == (xb >= wx)) return (xa >= wx) ? 1 : 0;
      den = yb - ya;
      q = (den != 0) ? ((ya - wy) * (xb - xa)) / den : 0;
      return ((xa - q) >= wx) ? 1 : 0;
   endfunction

   function bit in_polygon(int unsigned a, int n, longint wx, longint wy);
      int unsigned hits;
      int          last, p;
      longint      xv, yv;
      bit          above;
      hits = 0;
      last = (n / 2) * 2;
      p = 1;
      xv = coord_at(a, last - 2);
      yv = coord_at(a, last - 1);
      if ((yv >= wy) != (coord_at(a, 1) >= wy))
         hits += crossing(xv, yv, coord_at(a, 0), coord_at(a, 1), wx, wy);
      while (p < last) begin
         yv = coord_at(a, p);
         p += 2;
         above = (yv >= wy);
         while (p < last && ((coord_at(a, p) >= wy) == above)) p += 2;
         if (p >= last) break;
         hits += crossing(coord_at(a, p - 3), coord_at(a, p - 2),
                          coord_at(a, p - 1), coord_at(a, p), wx, wy);
      end
      return hits[0];
   endfunction

   function bit contains(int unsigned a, longint x, longint y);
      int     n;
      longint dx, dy, r;
      n = len[a];
      case (shp[a])
         imh_pkg::SHAPE_RECT: begin
            if (n < imh_pkg::RECT_MIN) return 0;
            if (coord_at(a, 0) > coord_at(a, 2) || coord_at(a, 1) > coord_at(a, 3))
               return 0;
            return x >= coord_at(a, 0) && x <= coord_at(a, 2) &&
                   y >= coord_at(a, 1) && y <= coord_at(a, 3);
         end
         imh_pkg::SHAPE_CIRCLE: begin
            if (n < imh_pkg::CIRCLE_MIN) return 0;
            r = coord_at(a, 2);
            if (r < 0) return 0;
            dx = coord_at(a, 0) - x;
            dy = coord_at(a, 1) - y;
            return dx * dx + dy * dy <= r * r;
         end
         imh_pkg::SHAPE_POLY: begin
            if (n < imh_pkg::POLY_MIN) return 0;
            return in_polygon(a, n, x, y);
         end
         default: return 1;
      endcase
   endfunction

   // note an accepted request and queue its expected response
   function void note_request(logic [2:0] kind, logic [55:0] d);
      logic [1:0] sts;
      logic       hit, lnk, sup;
      logic [3:0] idx;
      longint     x, y;
      sts = imh_pkg::STS_OK;
      hit = 0; lnk = 0; sup = 0; idx = 0;
      x = longint'($signed(d[36:21]));
      y = longint'($signed(d[52:37]));
      case (kind)
         imh_pkg::KIND_CLEAR: begin
            n_areas = 0;
            fill = 0;
         end
         imh_pkg::KIND_OPEN: begin
            if (n_areas >= 16) sts = imh_pkg::STS_TABLE_FULL;
            else begin
               shp[n_areas] = d[1:0];
               flg[n_areas] = d[4:2];
               st[n_areas] = fill;
               len[n_areas] = 0;
               n_areas++;
            end
         end
         imh_pkg::KIND_APPEND: begin
            if (n_areas == 0) sts = imh_pkg::STS_NO_AREA;
            else if (fill >= 256) sts = imh_pkg::STS_STORE_FULL;
            else begin
               crds[fill] = longint'($signed(d[20:5]));
               fill++;
               len[n_areas-1]++;
            end
         end
         imh_pkg::KIND_FIRST: begin
            for (int i = 0; i < n_areas; i++)
               if (contains(i, x, y)) begin
                  hit = 1;
                  idx = 4'(i);
                  lnk = flg[i][imh_pkg::FLAG_URL];
                  sup = flg[i][imh_pkg::FLAG_SUP];
                  break;
               end
         end
         imh_pkg::KIND_LINK: begin
            for (int i = 0; i < n_areas; i++)
               if (contains(i, x, y) && flg[i][imh_pkg::FLAG_HREF]) begin
                  hit = 1;
                  break;
               end
         end
         default: ;
      endcase
      pending.push_back({sup, lnk, idx, hit, sts});
   endfunction

   function void check_response(logic [15:0] got);
      logic [8:0] want;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected response %h", got);
         return;
      end
      want = pending.pop_front();
      if (got !== {7'd0, want}) begin
         errors++;
         if (errors <= 10)
            $display({"mismatch: status %0d/%0d hit %0d/%0d idx %0d/%0d",
                      " link %0d/%0d sup %0d/%0d"},
                     want[1:0], got[1:0], want[2], got[2], want[6:3], got[6:3],
                     want[7], got[7], want[8], got[8]);
      end
   endfunction
endclass

module tb_image_map_hit_test;
   import imh_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;

   hit_scoreboard board = new();
   int unsigned   cycles = 0;
   bit            calm = 0;      // set for a stretch with no idling on either side

   localparam int unsigned CYCLE_LIMIT = 25_000_000;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   image_map_hit_test uut (.*);

   // response side: random back-pressure, sample at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end
   always @(negedge clock)
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 29);

   always @(posedge clock)
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end

   // optionally idle first, then present one item and hold it until taken
   task automatic send_item(logic [2:0] kind, logic [55:0] d);
      while (!calm && $urandom_range(99) < 29) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, d);
      @(negedge clock);
   endtask

   function automatic logic [55:0] pack(logic [1:0] shape, logic [2:0] flags,
                                        logic [15:0] c, logic [15:0] x,
                                        logic [15:0] y);
      return {3'b000, y, x, c, flags, shape};
   endfunction

   task automatic open_area(logic [1:0] shape);
      send_item(KIND_OPEN, pack(shape, 3'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom)));
   endtask

   task automatic add_coord(logic [15:0] c);
      send_item(KIND_APPEND, pack(2'($urandom), 3'($urandom), c, 16'($urandom),
                                  16'($urandom)));
   endtask

   task automatic ask(logic [2:0] kind, logic [15:0] x, logic [15:0] y);
      send_item(kind, pack(2'($urandom), 3'($urandom), 16'($urandom), x, y));
   endtask

   // coordinates mostly from a small window so shapes and points meet
   function automatic logic [15:0] near_val();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(80)) - 40);
      endcase
   endfunction

   initial begin
      int items;
      int calm_from;
      logic [1:0] s;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: no-area append, rect, circle and polygon areas with edge cases, both queries
      add_coord(16'sd5);
      ask(KIND_FIRST, 16'd0, 16'd0);
      open_area(SHAPE_RECT); add_coord(-16'sd10); add_coord(-16'sd10);
      add_coord(16'sd10); add_coord(16'sd10);
      open_area(SHAPE_RECT); add_coord(16'sd5); add_coord(16'sd0);
      add_coord(-16'sd5); add_coord(16'sd9);
      open_area(SHAPE_CIRCLE); add_coord(16'sd100); add_coord(16'sd100);
      add_coord(-16'sd1);
      open_area(SHAPE_CIRCLE); add_coord(16'h8000); add_coord(16'h7FFF);
      add_coord(16'h7FFF); add_coord(16'sd3);
      open_area(SHAPE_POLY); add_coord(16'sd0); add_coord(16'sd0);
      add_coord(16'sd20); add_coord(16'sd0);
      add_coord(16'sd10); add_coord(16'sd20); add_coord(16'sd7);
      ask(KIND_FIRST, 16'd10, 16'd10); ask(KIND_LINK, 16'h8000, 16'h7FFF);
      send_item(3'd5, '1); send_item(3'd7, '0);
      send_item(KIND_CLEAR, '0);

      // random: mostly well-formed area tables, then queries; calm window midway
      items = 0;
      calm_from = -1;
      while (items < 1170) begin
         if (calm_from < 0 && items >= 500) calm_from = items;
         calm = (calm_from >= 0 && items < calm_from + 150);
         if ($urandom_range(19) == 0) begin
            send_item(KIND_CLEAR, '0); items++;
            for (int k = 0; k < 18; k++) begin
               open_area(2'($urandom)); items++;
            end
         end
         if (items < 900 && $urandom_range(7) == 0) begin
            send_item(KIND_CLEAR, '0); items++;
            open_area(2'd1); add_coord(16'd0); items += 2;
            for (int k = 0; k < 260; k++) begin
               add_coord(16'($urandom)); items++;
            end
            open_area(2'd1); ask(KIND_FIRST, 16'($urandom), 16'($urandom)); items += 2;
            send_item(KIND_CLEAR, '0); items++;
         end
         for (int a = $urandom_range(4, 1); a > 0; a--) begin
            s = 2'($urandom);
            open_area(s); items++;
            for (int k = $urandom_range(s == SHAPE_POLY ? 12 : 5); k > 0; k--) begin
               add_coord(near_val()); items++;
            end
         end
         for (int q = $urandom_range(8, 2); q > 0; q--) begin
            ask($urandom_range(1) ? KIND_FIRST : KIND_LINK, near_val(), near_val());
            items++;
         end
         if ($urandom_range(9) == 0) begin
            send_item(3'($urandom_range(7)), 56'({$urandom, $urandom})); items++;
         end
         if ($urandom_range(2) == 0) begin
            send_item(KIND_CLEAR, '0); items++;
         end
      end
      req_tvalid <= 0;
      calm = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
